// ===== design/rsod_pkg.sv =====
// Shared types, codes and constants for the ranging sensor obstacle detector.
// Used by every module of the detector except rsod_ram; depends on nothing else.
`default_nettype none

package rsod_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 4;
   localparam int SAMPLE_BITS_DEFAULT  = 10;

   localparam int SENSOR_COUNT = 6;
   localparam int SENSOR_W     = 3;
   localparam int VALUE_W      = 10;
   localparam int THRESH_W     = 16;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd1300;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'd0;

   // sensor groups scanned for each direction
   localparam logic [SENSOR_W-1:0] FWD_FIRST = 3'd0;
   localparam logic [SENSOR_W-1:0] FWD_LAST  = 3'd3;
   localparam logic [SENSOR_W-1:0] REV_FIRST = 3'd4;
   localparam logic [SENSOR_W-1:0] REV_LAST  = 3'd5;

   typedef enum logic [1:0] {
      CMD_STORE       = 2'd0,
      CMD_EVAL_CHANGE = 2'd1,
      CMD_EVAL_SIDE   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_BLOCKED = 2'd1,
      EV_CLEARED = 2'd2
   } event_type;

   // controller -> datapath
   typedef struct packed {
      logic                capture;
      logic                clear_wr;
      logic                store_first;
      logic                store_second;
      logic                rd_issue;
      logic [SENSOR_W-1:0] scan_sensor;
      logic                emit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic slot_last;
      logic rsp_free;
   } ctrl_status_type;

   // converter one visits sensors 0, 1, 4, 5
   function automatic logic [SENSOR_W-1:0] first_sensor(input logic [1:0] idx);
      logic [SENSOR_W-1:0] s;
      case (idx)
         2'd0:    s = 3'd0;
         2'd1:    s = 3'd1;
         2'd2:    s = 3'd4;
         default: s = 3'd5;
      endcase
      return s;
   endfunction

   // converter two visits sensors 3, 2
   function automatic logic [SENSOR_W-1:0] second_sensor(input logic idx);
      return idx ? 3'd2 : 3'd3;
   endfunction

endpackage

`default_nettype wire

// ===== design/ranging_sensor_obstacle_detector_core.sv =====
// Obstacle detector for six ranging sensors: a store command writes one sample from each
// converter into that sensor's ring (the transfer, then two writes on the single write
// port); an evaluate command sums the rings of the forward group (sensors 0..3) or the
// reverse group (4, 5) one memory entry per cycle on the single read port and returns one
// result, held back while the result register waits on rsp_stall. After reset a
// clearing pass zeroes every entry of the sample memory, with req_stall held high; the
// threshold register can be written during that pass.
// Depends on rsod_pkg, rsod_csr, rsod_ctrl, rsod_datapath and rsod_ram.
`default_nettype none

module ranging_sensor_obstacle_detector_core #(
   parameter int WINDOW_DEPTH = rsod_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS  = rsod_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_command,
   input  wire logic [rsod_pkg::VALUE_W-1:0]    req_first_value,
   input  wire logic                            req_first_done,
   input  wire logic [rsod_pkg::VALUE_W-1:0]    req_second_value,
   input  wire logic                            req_second_done,
   input  wire logic                            req_forward,
   input  wire logic                            req_side_select,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [1:0]                      rsp_event_code,
   output logic                                 rsp_obstacle_seen,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rsod_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [rsod_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [rsod_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import rsod_pkg::*;

   logic [THRESH_W-1:0] threshold;
   ctrl_cmd_type        cmd;
   ctrl_status_type     status;

   rsod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   rsod_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_forward (req_forward),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   rsod_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_first_value   (req_first_value),
      .req_first_done    (req_first_done),
      .req_second_value  (req_second_value),
      .req_second_done   (req_second_done),
      .req_forward       (req_forward),
      .req_side_select   (req_side_select),
      .threshold         (threshold),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_obstacle_seen (rsp_obstacle_seen)
   );

endmodule

`default_nettype wire

// ===== design/rsod_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rsod_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/rsod_csr.sv =====
// Configuration register block: distance threshold behind an APB-style port.
// Depends on rsod_pkg.
`default_nettype none

module rsod_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [rsod_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rsod_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [rsod_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output logic      [rsod_pkg::THRESH_W-1:0]    threshold
);
   import rsod_pkg::*;

   logic [THRESH_W-1:0]  threshold_ff;
   logic [THRESH_W-1:0]  threshold_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_hit;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_hit  = psel & penable & pwrite & pready & (reg_idx == REG_THRESHOLD);

   always_comb begin
      threshold_in = threshold_ff;
      if (wr_hit) begin
         threshold_in = pwdata[THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign prdata    = (reg_idx == REG_THRESHOLD) ? CSR_DATA_W'(threshold_ff) : '0;
   assign threshold = threshold_ff;

endmodule

`default_nettype wire

// ===== design/rsod_ctrl.sv =====
// Controller state machine: memory clear, sample store and window scan sequencing.
// Depends on rsod_pkg; drives the datapath through ctrl_cmd_type.
`default_nettype none

module rsod_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [1:0]                    req_command,
   input  wire logic                          req_forward,
   output logic                               req_stall,
   input  wire rsod_pkg::ctrl_status_type     status,
   output rsod_pkg::ctrl_cmd_type             cmd
);
   import rsod_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_STORE1 = 7'b0000100,
      ST_STORE2 = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [SENSOR_W-1:0] sensor_ff, sensor_in;
   logic [SENSOR_W-1:0] last_sensor_ff, last_sensor_in;
   logic                accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in       = state_ff;
      sensor_in      = sensor_ff;
      last_sensor_in = last_sensor_ff;
      cmd            = '0;
      cmd.capture    = accept;
      cmd.scan_sensor = sensor_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_STORE: begin
                     state_in = ST_STORE1;
                  end
                  CMD_EVAL_CHANGE, CMD_EVAL_SIDE: begin
                     state_in       = ST_SCAN;
                     sensor_in      = req_forward ? FWD_FIRST : REV_FIRST;
                     last_sensor_in = req_forward ? FWD_LAST : REV_LAST;
                  end
                  default: begin
                     state_in = ST_IDLE;   // unused code, dropped
                  end
               endcase
            end
         end
         ST_STORE1: begin
            cmd.store_first = 1'b1;
            state_in        = ST_STORE2;
         end
         ST_STORE2: begin
            cmd.store_second = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
            if (status.slot_last) begin
               if (sensor_ff == last_sensor_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  sensor_in = sensor_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         sensor_ff      <= '0;
         last_sensor_ff <= '0;
      end else begin
         state_ff       <= state_in;
         sensor_ff      <= sensor_in;
         last_sensor_ff <= last_sensor_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rsod_datapath.sv =====
// Datapath: sample memory, ring indices, window accumulator, threshold compare,
// blocked latch and result register. Depends on rsod_pkg and rsod_ram.
`default_nettype none

module rsod_datapath #(
   parameter int WINDOW_DEPTH = rsod_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS  = rsod_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [1:0]                      req_command,
   input  wire logic [rsod_pkg::VALUE_W-1:0]    req_first_value,
   input  wire logic                            req_first_done,
   input  wire logic [rsod_pkg::VALUE_W-1:0]    req_second_value,
   input  wire logic                            req_second_done,
   input  wire logic                            req_forward,
   input  wire logic                            req_side_select,
   input  wire logic [rsod_pkg::THRESH_W-1:0]   threshold,
   input  wire rsod_pkg::ctrl_cmd_type          cmd,
   output rsod_pkg::ctrl_status_type            status,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [1:0]                      rsp_event_code,
   output logic                                 rsp_obstacle_seen
);
   import rsod_pkg::*;

   localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int ADDR_W    = SENSOR_W + SLOT_W;
   localparam int RAM_DEPTH = SENSOR_COUNT * (1 << SLOT_W);
   localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W     = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
   localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [ADDR_W-1:0] CLEAR_MAX = ADDR_W'(RAM_DEPTH - 1);

   // captured item
   logic [1:0]         cmd_ff;
   logic               fwd_ff;
   logic               side_ff;
   logic [VALUE_W-1:0] first_value_ff;
   logic               first_done_ff;
   logic [VALUE_W-1:0] second_value_ff;
   logic               second_done_ff;

   // ring positions
   logic [1:0]          first_idx_ff, first_idx_in;
   logic [SLOT_W-1:0]   first_slot_ff, first_slot_in;
   logic                second_idx_ff, second_idx_in;
   logic [SLOT_W-1:0]   second_slot_ff, second_slot_in;

   // clear sweep and scan
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [SLOT_W-1:0]   scan_slot_ff, scan_slot_in;
   logic                rd_valid_ff;
   logic                rd_first_ff;
   logic                rd_last_ff;
   logic [SENSOR_W-1:0] rd_sensor_ff;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SENSOR_COUNT-1:0] above_ff, above_in;

   logic                blocked_ff, blocked_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_event_ff, rsp_event_in;
   logic                rsp_seen_ff, rsp_seen_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [SAMPLE_BITS-1:0]  wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   logic [SAMPLE_BITS-1:0]  rd_data;
   logic [SUM_W-1:0]        sum;
   logic                    group_seen;
   logic                    side_seen;
   logic                    seen;

   // ---- sample memory ----
   always_comb begin
      wr_en   = cmd.clear_wr | cmd.store_first | cmd.store_second;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      if (cmd.store_first) begin
         wr_addr = {first_sensor(first_idx_ff), first_slot_ff};
         wr_data = first_done_ff ? SAMPLE_BITS'(first_value_ff) : '0;
      end else if (cmd.store_second) begin
         wr_addr = {second_sensor(second_idx_ff), second_slot_ff};
         wr_data = second_done_ff ? SAMPLE_BITS'(second_value_ff) : '0;
      end
   end

   assign rd_addr = {cmd.scan_sensor, scan_slot_ff};

   rsod_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- ring indices and clear sweep ----
   always_comb begin
      first_idx_in   = first_idx_ff;
      first_slot_in  = first_slot_ff;
      second_idx_in  = second_idx_ff;
      second_slot_in = second_slot_ff;
      if (cmd.store_second) begin
         first_idx_in  = first_idx_ff + 1'b1;
         second_idx_in = ~second_idx_ff;
         // slot moves on when the converter's sensor cycle wraps
         if (first_idx_ff == 2'd3) begin
            first_slot_in = (first_slot_ff == SLOT_MAX) ? '0 : first_slot_ff + 1'b1;
         end
         if (second_idx_ff) begin
            second_slot_in = (second_slot_ff == SLOT_MAX) ? '0 : second_slot_ff + 1'b1;
         end
      end
      clr_addr_in = cmd.clear_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   // ---- window scan ----
   always_comb begin
      scan_slot_in = scan_slot_ff;
      if (cmd.rd_issue) begin
         scan_slot_in = (scan_slot_ff == SLOT_MAX) ? '0 : scan_slot_ff + 1'b1;
      end
      sum      = rd_first_ff ? SUM_W'(rd_data) : acc_ff + SUM_W'(rd_data);
      acc_in   = rd_valid_ff ? sum : acc_ff;
      above_in = above_ff;
      if (cmd.capture) begin
         above_in = '0;
      end else if (rd_valid_ff && rd_last_ff) begin
         above_in[rd_sensor_ff] = CMP_W'(sum) > CMP_W'(threshold);
      end
   end

   // ---- decision and result register ----
   always_comb begin
      group_seen = fwd_ff ? (|above_ff[3:0]) : (|above_ff[5:4]);
      if (fwd_ff) begin
         side_seen = side_ff ? (above_ff[0] | above_ff[2]) : (above_ff[1] | above_ff[3]);
      end else begin
         side_seen = side_ff ? above_ff[4] : above_ff[5];
      end
      seen         = (cmd_ff == CMD_EVAL_CHANGE) ? group_seen : side_seen;
      blocked_in   = blocked_ff;
      rsp_event_in = rsp_event_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_seen_in  = seen;
         rsp_event_in = EV_NONE;
         if (cmd_ff == CMD_EVAL_CHANGE) begin
            if (seen && !blocked_ff) begin
               blocked_in   = 1'b1;
               rsp_event_in = EV_BLOCKED;
            end else if (!seen && blocked_ff) begin
               blocked_in   = 1'b0;
               rsp_event_in = EV_CLEARED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_idx_ff   <= '0;
         first_slot_ff  <= '0;
         second_idx_ff  <= 1'b0;
         second_slot_ff <= '0;
         clr_addr_ff    <= '0;
         scan_slot_ff   <= '0;
         rd_valid_ff    <= 1'b0;
         above_ff       <= '0;
         blocked_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         first_idx_ff   <= first_idx_in;
         first_slot_ff  <= first_slot_in;
         second_idx_ff  <= second_idx_in;
         second_slot_ff <= second_slot_in;
         clr_addr_ff    <= clr_addr_in;
         scan_slot_ff   <= scan_slot_in;
         rd_valid_ff    <= cmd.rd_issue;
         above_ff       <= above_in;
         blocked_ff     <= blocked_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff          <= req_command;
         fwd_ff          <= req_forward;
         side_ff         <= req_side_select;
         first_value_ff  <= req_first_value;
         first_done_ff   <= req_first_done;
         second_value_ff <= req_second_value;
         second_done_ff  <= req_second_done;
      end
      rd_first_ff  <= (scan_slot_ff == '0);
      rd_last_ff   <= (scan_slot_ff == SLOT_MAX);
      rd_sensor_ff <= cmd.scan_sensor;
      acc_ff       <= acc_in;
      rsp_event_ff <= rsp_event_in;
      rsp_seen_ff  <= rsp_seen_in;
   end

   assign status.clear_last = (clr_addr_ff == CLEAR_MAX);
   assign status.slot_last  = (scan_slot_ff == SLOT_MAX);
   assign status.rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_code    = rsp_event_ff;
   assign rsp_obstacle_seen = rsp_seen_ff;

endmodule

`default_nettype wire

// ===== design/rsod_checker.sv =====
// Port-level checks for the obstacle detector core, bound to the top level.
// Depends on rsod_pkg.
`default_nettype none

module rsod_port_checks (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_command,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_event_code,
   input wire logic       rsp_obstacle_seen,
   input wire logic       pready
);
   import rsod_pkg::*;

   // a result waiting on stall keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
                                 && $stable(rsp_obstacle_seen))
      else $error("result changed while stalled");

   // memory clear keeps the input closed right after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open during clearing pass");

   // event code agrees with the obstacle flag
   a_event_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_code == EV_NONE)
                    || (rsp_event_code == EV_BLOCKED && rsp_obstacle_seen)
                    || (rsp_event_code == EV_CLEARED && !rsp_obstacle_seen))
      else $error("bad event code");

   // a store transfer never produces a result
   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_STORE && !rsp_valid
      |=> !rsp_valid)
      else $error("result after store");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind ranging_sensor_obstacle_detector_core rsod_port_checks u_rsod_port_checks (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_code    (rsp_event_code),
   .rsp_obstacle_seen (rsp_obstacle_seen),
   .pready            (pready)
);

`default_nettype wire

// ===== dv/rsod_checker.sv =====
// Scoreboard for the ranging sensor obstacle detector: tracks threshold writes and sample
// transfers, predicts each evaluate report and compares it with the response channel.
// Depends on rsod_pkg.
`default_nettype none

module rsod_checker
   import rsod_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [1:0]            req_command,
   input  wire logic [VALUE_W-1:0]    req_first_value,
   input  wire logic                  req_first_done,
   input  wire logic [VALUE_W-1:0]    req_second_value,
   input  wire logic                  req_second_done,
   input  wire logic                  req_forward,
   input  wire logic                  req_side_select,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [1:0]            rsp_event_code,
   input  wire logic                  rsp_obstacle_seen,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         fail_count,
   output int                         open_count
);

   localparam int DEPTH = WINDOW_DEPTH_DEFAULT;
   localparam int SAMPLE_MASK = (1 << SAMPLE_BITS_DEFAULT) - 1;
   localparam int CONV1_SENSOR [4] = '{0, 1, 4, 5};
   localparam int CONV2_SENSOR [2] = '{3, 2};

   typedef struct packed {
      event_type code;
      logic      seen;
   } report_t;

   report_t             expected_reports [$];
   logic [VALUE_W-1:0]  ring [SENSOR_COUNT][DEPTH];
   int                  conv1_pos;
   int                  conv1_slot;
   int                  conv2_pos;
   int                  conv2_slot;
   logic [THRESH_W-1:0] threshold;
   logic                blocked;
   int                  mismatches = 0;
   int                  pending    = 0;

   assign fail_count = mismatches;
   assign open_count = pending;

   function automatic bit sensor_over(input int s);
      int sum;
      sum = 0;
      for (int k = 0; k < DEPTH; k++) sum += ring[s][k];
      return sum > threshold;
   endfunction

   task automatic store_samples();
      int v1;
      int v2;
      v1 = req_first_done  ? (int'(req_first_value)  & SAMPLE_MASK) : 0;
      v2 = req_second_done ? (int'(req_second_value) & SAMPLE_MASK) : 0;
      ring[CONV1_SENSOR[conv1_pos]][conv1_slot] = v1[VALUE_W-1:0];
      ring[CONV2_SENSOR[conv2_pos]][conv2_slot] = v2[VALUE_W-1:0];
      // slot moves on only when the converter's sensor cycle wraps
      conv1_pos++;
      if (conv1_pos >= 4) begin
         conv1_pos  = 0;
         conv1_slot = (conv1_slot + 1) % DEPTH;
      end
      conv2_pos++;
      if (conv2_pos >= 2) begin
         conv2_pos  = 0;
         conv2_slot = (conv2_slot + 1) % DEPTH;
      end
   endtask

   task automatic predict_detection();
      report_t r;
      r.code = EV_NONE;
      case (req_command)
         CMD_STORE: begin
            store_samples();
         end
         CMD_EVAL_CHANGE: begin
            if (req_forward)
               r.seen = sensor_over(0) || sensor_over(1) || sensor_over(2) || sensor_over(3);
            else
               r.seen = sensor_over(4) || sensor_over(5);
            if (r.seen && !blocked) begin
               blocked = 1'b1;
               r.code  = EV_BLOCKED;
            end else if (!r.seen && blocked) begin
               blocked = 1'b0;
               r.code  = EV_CLEARED;
            end
            expected_reports.push_back(r);
         end
         CMD_EVAL_SIDE: begin
            if (req_forward)
               r.seen = req_side_select ? (sensor_over(0) || sensor_over(2))
                                        : (sensor_over(1) || sensor_over(3));
            else
               r.seen = req_side_select ? sensor_over(4) : sensor_over(5);
            expected_reports.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      report_t want;
      if (reset) begin
         for (int s = 0; s < SENSOR_COUNT; s++)
            for (int k = 0; k < DEPTH; k++) ring[s][k] = '0;
         conv1_pos  = 0;
         conv1_slot = 0;
         conv2_pos  = 0;
         conv2_slot = 0;
         threshold  = THRESHOLD_RESET;
         blocked    = 1'b0;
         expected_reports.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[CSR_ADDR_W-1:2] == REG_THRESHOLD)
            threshold = pwdata[THRESH_W-1:0];
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report: event_code %0d obstacle_seen %0d",
                      rsp_event_code, rsp_obstacle_seen);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_event_code !== want.code) begin
                  $error("event_code mismatch: expected %0d, actual %0d",
                         want.code, rsp_event_code);
                  mismatches++;
               end
               if (rsp_obstacle_seen !== want.seen) begin
                  $error("obstacle_seen mismatch: expected %0d, actual %0d",
                         want.seen, rsp_obstacle_seen);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) predict_detection();
      end
      pending = expected_reports.size();
   end

endmodule

`default_nettype wire

// ===== dv/tb_ranging_sensor_obstacle_detector_core.sv =====
// Testbench top for the ranging sensor obstacle detector: clock, reset, sample and
// evaluate stimulus, threshold writes and the verdict. Checking lives in rsod_checker.
// Depends on rsod_pkg, rsod_checker and ranging_sensor_obstacle_detector_core.
`default_nettype none

module tb_ranging_sensor_obstacle_detector_core;
   import rsod_pkg::*;

   localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT;
   localparam int DRAIN_CYCLES = 4 * WINDOW_DEPTH + 3 + 8;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 250;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED    = 3'd4;

   typedef enum int { LEVEL_LOW, LEVEL_HIGH, LEVEL_FULL } level_type;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_command       = CMD_STORE;
   logic [VALUE_W-1:0]    req_first_value   = '0;
   logic                  req_first_done    = 1'b0;
   logic [VALUE_W-1:0]    req_second_value  = '0;
   logic                  req_second_done   = 1'b0;
   logic                  req_forward       = 1'b0;
   logic                  req_side_select   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic [1:0]            rsp_event_code;
   logic                  rsp_obstacle_seen;
   logic                  psel              = 1'b0;
   logic                  penable           = 1'b0;
   logic                  pwrite            = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr             = '0;
   logic [CSR_DATA_W-1:0] pwdata            = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int        fail_count;
   int        open_count;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   level_type level = LEVEL_FULL;

   ranging_sensor_obstacle_detector_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_first_value   (req_first_value),
      .req_first_done    (req_first_done),
      .req_second_value  (req_second_value),
      .req_second_done   (req_second_done),
      .req_forward       (req_forward),
      .req_side_select   (req_side_select),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_obstacle_seen (rsp_obstacle_seen),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   rsod_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_first_value   (req_first_value),
      .req_first_done    (req_first_done),
      .req_second_value  (req_second_value),
      .req_second_done   (req_second_done),
      .req_forward       (req_forward),
      .req_side_select   (req_side_select),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_obstacle_seen (rsp_obstacle_seen),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .fail_count        (fail_count),
      .open_count        (open_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_item(input logic [1:0] cmd, input logic [VALUE_W-1:0] fv,
                            input logic fd, input logic [VALUE_W-1:0] sv, input logic sd,
                            input logic fw, input logic ss);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_first_value  <= fv;
      req_first_done   <= fd;
      req_second_value <= sv;
      req_second_done  <= sd;
      req_forward      <= fw;
      req_side_select  <= ss;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // drop valid, let every report come back, then give a trailing store time to finish
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '1;
      if (r < 8) return '0;
      case (level)
         LEVEL_LOW:  return VALUE_W'($urandom_range(0, 150));
         LEVEL_HIGH: return VALUE_W'($urandom_range(700, 1023));
         default:    return VALUE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   initial begin
      int          counted;
      int          pick;
      logic [1:0]  cmd;
      logic [15:0] thresholds [PHASES];

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset threshold, empty rings, then full-scale samples in every ring
      send_item(CMD_EVAL_CHANGE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b0);
      send_item(CMD_UNUSED, '1, 1'b1, '1, 1'b1, 1'b1, 1'b1);
      repeat (8) send_item(CMD_STORE, '1, 1'b1, '1, 1'b1, 1'b0, 1'b0);
      send_item(CMD_EVAL_CHANGE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b0);
      send_item(CMD_EVAL_CHANGE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b1);
      send_item(CMD_EVAL_SIDE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b0);
      send_item(CMD_EVAL_SIDE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b1);
      send_item(CMD_EVAL_SIDE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_EVAL_SIDE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
      send_item(CMD_EVAL_CHANGE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      // missing conversions store zero even with a full-scale value present
      repeat (8) send_item(CMD_STORE, '1, 1'b0, '1, 1'b0, 1'b1, 1'b1);
      send_item(CMD_EVAL_SIDE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b0);
      send_item(CMD_EVAL_CHANGE, '0, 1'b0, '0, 1'b0, 1'b1, 1'b0);
      drain();

      thresholds[0] = 16'hFFFF;
      thresholds[1] = 16'h0000;
      thresholds[2] = 16'd2000;
      thresholds[3] = 16'($urandom_range(0, 4100));
      thresholds[4] = 16'd700;
      thresholds[5] = 16'd3000;
      thresholds[6] = THRESHOLD_RESET;
      thresholds[7] = 16'($urandom_range(0, 4100));

      // index past the register list must be ignored
      csr_write(ADDR_UNUSED, $urandom);

      for (int ph = 0; ph < PHASES; ph++) begin
         csr_write(ADDR_THRESHOLD, {16'($urandom), thresholds[ph]});
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // switch sample level now and then so window sums cross the threshold
            if ($urandom_range(24) == 0) level = level_type'($urandom_range(2));
            pick = $urandom_range(99);
            if (pick < 55)      cmd = CMD_STORE;
            else if (pick < 75) cmd = CMD_EVAL_CHANGE;
            else if (pick < 95) cmd = CMD_EVAL_SIDE;
            else                cmd = CMD_UNUSED;
            send_item(cmd, pick_sample(), $urandom_range(99) < 85, pick_sample(),
                      $urandom_range(99) < 85, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            if (cmd != CMD_UNUSED) counted++;
         end
         drain();
      end

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/rsod_pkg.sv
design/rsod_ram.sv
design/rsod_csr.sv
design/rsod_ctrl.sv
design/rsod_datapath.sv
design/ranging_sensor_obstacle_detector_core.sv
design/rsod_checker.sv
dv/rsod_checker.sv
dv/tb_ranging_sensor_obstacle_detector_core.sv
